### design/taaep_pkg.sv
`timescale 1ns / 1ps
package taaep_pkg;
   localparam int AngleBits = 34;
   localparam logic signed [AngleBits-1:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic [15:0] InvGainQ16 = 16'd39797;

   // Register indexes
   localparam logic [1:0] RegAzLeft  = 2'd0;
   localparam logic [1:0] RegAzRight = 2'd1;
   localparam logic [1:0] RegElLower = 2'd2;
   localparam logic [1:0] RegElUpper = 2'd3;

   // floor(2^30 * atan(2^-i))
   function automatic logic signed [AngleBits-1:0] atan_entry(input int i);
      logic signed [AngleBits-1:0] r;
      r = '0;
      unique case (i)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021686;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         default: begin
            if (i <= 30) r = (34'sd1 <<< (30 - i)) - 34'sd1;
            else r = '0;
         end
      endcase
      return r;
   endfunction
endpackage

### design/track_antenna_az_el_pointing.sv
`timescale 1ns / 1ps
// Channel  | Ports                              | Direction
// ---------+------------------------------------+----------
// request  | req_valid, req_stall, req_*        | in
// response | rsp_valid, rsp_stall, rsp_*        | out
// csr      | csr_write, csr_index, csr_data     | in
// One transaction per cycle while the response is not stalled. The pipeline holds
// two rotation-product stages, one prerotation stage per CORDIC, one stage
// per CORDIC iteration, the gain multiply and the clamp/round stage.
// Synchronous reset clears all valid bits and loads the default limits.
// A stall on a valid response freezes the whole pipeline; req_stall follows it.
module track_antenna_az_el_pointing
   import taaep_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_track_present,
   input  logic signed [POSITION_BITS-1:0] req_rel_north,
   input  logic signed [POSITION_BITS-1:0] req_rel_east,
   input  logic signed [POSITION_BITS-1:0] req_rel_down,
   input  logic signed [15:0]              req_sin_heading,
   input  logic signed [15:0]              req_cos_heading,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_ref_azimuth,
   output logic signed [14:0]              rsp_ref_elevation,
   output logic                            rsp_scan_mode,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [15:0]                     csr_data
);
   // Datapath widths: positions in Q.12, DW adds 3 bits to PW for CORDIC growth
   localparam int PW = POSITION_BITS + 16;
   localparam int DW = PW + 3;
   localparam int NS = CORDIC_STEPS;

   logic adv;
   assign adv = !rsp_stall || !rsp_valid;
   assign req_stall = !adv;

   // Limit registers
   logic signed [15:0] az_left_ff, az_right_ff;
   logic signed [14:0] el_lower_ff, el_upper_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         az_left_ff  <= -16'sd25736;
         az_right_ff <= 16'sd25736;
         el_lower_ff <= -15'sd12868;
         el_upper_ff <= 15'sd12868;
      end else if (csr_write) begin
         unique case (csr_index)
            RegAzLeft:  az_left_ff  <= csr_data;
            RegAzRight: az_right_ff <= csr_data;
            RegElLower: el_lower_ff <= csr_data[14:0];
            RegElUpper: el_upper_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Stage 1: the four heading products
   logic                    s1_v_ff, s1_t_ff;
   logic signed [PW-1:0]    p_nc_ff, p_es_ff, p_ec_ff, p_ns_ff;
   logic signed [DW-1:0]    s1_z_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
      if (adv) begin
         s1_t_ff <= req_track_present;
         p_nc_ff <= PW'(req_rel_north) * req_cos_heading;
         p_es_ff <= PW'(req_rel_east) * req_sin_heading;
         p_ec_ff <= PW'(req_rel_east) * req_cos_heading;
         p_ns_ff <= PW'(req_rel_north) * req_sin_heading;
         // -down in Q.12
         s1_z_ff <= -(DW'(req_rel_down) <<< 12);
      end
   end

   // Stage 2: rotated x/y
   logic                 s2_v_ff, s2_t_ff;
   logic signed [DW-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv) begin
         s2_t_ff <= s1_t_ff;
         s2_x_ff <= DW'(p_nc_ff >>> 3) + DW'(p_es_ff >>> 3);
         s2_y_ff <= DW'(p_ec_ff >>> 3) - DW'(p_ns_ff >>> 3);
         s2_z_ff <= s1_z_ff;
      end
   end

   // Azimuth CORDIC: prerotation stage + NS iteration stages
   logic                        av_ff [NS+1];
   logic                        at_ff [NS+1];
   logic signed [DW-1:0]        ax_ff [NS+1];
   logic signed [DW-1:0]        ay_ff [NS+1];
   logic signed [AngleBits-1:0] aa_ff [NS+1];
   logic                        azero_ff [NS+1];
   logic signed [DW-1:0]        az_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) av_ff[0] <= 1'b0;
      else if (adv) av_ff[0] <= s2_v_ff;
      if (adv) begin
         at_ff[0] <= s2_t_ff;
         az_ff[0] <= s2_z_ff;
         azero_ff[0] <= (s2_x_ff == '0) && (s2_y_ff == '0);
         if (s2_x_ff < 0) begin
            if (s2_y_ff >= 0) begin
               ax_ff[0] <= s2_y_ff; ay_ff[0] <= -s2_x_ff; aa_ff[0] <= HalfPiQ30;
            end else begin
               ax_ff[0] <= -s2_y_ff; ay_ff[0] <= s2_x_ff; aa_ff[0] <= -HalfPiQ30;
            end
         end else begin
            ax_ff[0] <= s2_x_ff; ay_ff[0] <= s2_y_ff; aa_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_az
      always_ff @(posedge clock) begin
         if (reset) av_ff[i+1] <= 1'b0;
         else if (adv) av_ff[i+1] <= av_ff[i];
         if (adv) begin
            at_ff[i+1] <= at_ff[i];
            az_ff[i+1] <= az_ff[i];
            azero_ff[i+1] <= azero_ff[i];
            if (ay_ff[i] >= 0) begin
               ax_ff[i+1] <= ax_ff[i] + (ay_ff[i] >>> i);
               ay_ff[i+1] <= ay_ff[i] - (ax_ff[i] >>> i);
               aa_ff[i+1] <= aa_ff[i] + atan_entry(i);
            end else begin
               ax_ff[i+1] <= ax_ff[i] - (ay_ff[i] >>> i);
               ay_ff[i+1] <= ay_ff[i] + (ax_ff[i] >>> i);
               aa_ff[i+1] <= aa_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // Gain correction: two 16-bit-constant partial products, then sum
   logic                 gv_ff, gt_ff;
   logic signed [DW-1:0] gz_ff;
   logic [DW+15:0]       g_hi_ff, g_lo_ff;
   logic signed [AngleBits-1:0] g_az_ff;
   logic [DW-1:0]        mag_u;
   assign mag_u = azero_ff[NS] ? '0 : ax_ff[NS];
   always_ff @(posedge clock) begin
      if (reset) gv_ff <= 1'b0;
      else if (adv) gv_ff <= av_ff[NS];
      if (adv) begin
         gt_ff  <= at_ff[NS];
         gz_ff  <= az_ff[NS];
         g_az_ff <= azero_ff[NS] ? '0 : aa_ff[NS];
         g_hi_ff <= (DW+16)'(mag_u >> 16) * InvGainQ16;
         g_lo_ff <= ((DW+16)'(mag_u[15:0]) * InvGainQ16) >> 16;
      end
   end

   // Elevation CORDIC
   logic                        ev_ff [NS+1];
   logic                        et_ff [NS+1];
   logic signed [DW-1:0]        ex_ff [NS+1];
   logic signed [DW-1:0]        ey_ff [NS+1];
   logic signed [AngleBits-1:0] ea_ff [NS+1];
   logic                        ezero_ff [NS+1];
   logic signed [AngleBits-1:0] eaz_ff [NS+1];
   logic signed [DW-1:0]        g_val;
   assign g_val = DW'(g_hi_ff + g_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) ev_ff[0] <= 1'b0;
      else if (adv) ev_ff[0] <= gv_ff;
      if (adv) begin
         et_ff[0] <= gt_ff;
         eaz_ff[0] <= g_az_ff;
         ezero_ff[0] <= (g_val == '0) && (gz_ff == '0);
         if (g_val < 0) begin
            if (gz_ff >= 0) begin
               ex_ff[0] <= gz_ff; ey_ff[0] <= -g_val; ea_ff[0] <= HalfPiQ30;
            end else begin
               ex_ff[0] <= -gz_ff; ey_ff[0] <= g_val; ea_ff[0] <= -HalfPiQ30;
            end
         end else begin
            ex_ff[0] <= g_val; ey_ff[0] <= gz_ff; ea_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_el
      always_ff @(posedge clock) begin
         if (reset) ev_ff[i+1] <= 1'b0;
         else if (adv) ev_ff[i+1] <= ev_ff[i];
         if (adv) begin
            et_ff[i+1] <= et_ff[i];
            eaz_ff[i+1] <= eaz_ff[i];
            ezero_ff[i+1] <= ezero_ff[i];
            ex_ff[i+1] <= (ey_ff[i] >= 0) ? ex_ff[i] + (ey_ff[i] >>> i)
                                          : ex_ff[i] - (ey_ff[i] >>> i);
            ey_ff[i+1] <= (ey_ff[i] >= 0) ? ey_ff[i] - (ex_ff[i] >>> i)
                                          : ey_ff[i] + (ex_ff[i] >>> i);
            ea_ff[i+1] <= (ey_ff[i] >= 0) ? ea_ff[i] + atan_entry(i)
                                          : ea_ff[i] - atan_entry(i);
         end
      end
   end

   // Round to Q3.13 (azimuth) and Q2.13 (elevation) and clamp
   logic signed [AngleBits-1:0] el_a, az_q, el_q, az_c, el_c;
   always_comb begin
      el_a = ezero_ff[NS] ? '0 : ea_ff[NS];
      az_q = (eaz_ff[NS] + AngleBits'(65536)) >>> 17;
      el_q = (el_a + AngleBits'(65536)) >>> 17;
      if (az_q < AngleBits'(az_left_ff)) az_c = AngleBits'(az_left_ff);
      else if (az_q > AngleBits'(az_right_ff)) az_c = AngleBits'(az_right_ff);
      else az_c = az_q;
      if (el_q < AngleBits'(el_lower_ff)) el_c = AngleBits'(el_lower_ff);
      else if (el_q > AngleBits'(el_upper_ff)) el_c = AngleBits'(el_upper_ff);
      else el_c = el_q;
   end

   logic               rsp_valid_ff, rsp_scan_ff;
   logic signed [15:0] rsp_az_ff;
   logic signed [14:0] rsp_el_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= ev_ff[NS];
      if (adv) begin
         rsp_scan_ff <= !et_ff[NS];
         rsp_az_ff <= et_ff[NS] ? az_c[15:0] : '0;
         rsp_el_ff <= et_ff[NS] ? el_c[14:0] : '0;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ref_azimuth = rsp_az_ff;
   assign rsp_ref_elevation = rsp_el_ff;
   assign rsp_scan_mode = rsp_scan_ff;
endmodule
